// ----- hw/rtl/ftc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum cull test package
// Shared widths, register indexes, the plane layout and the verdict codes.
// ----------------------------------------------------------------------------
package ftc_pkg;

    localparam int COORD_W        = 16;
    localparam int RADIUS_W       = 15;
    localparam int FRAC_BITS      = 14;
    localparam int THR_W          = RADIUS_W + FRAC_BITS;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int DIST_W         = PROD_W + 2;
    localparam int AXES           = 3;
    localparam int PLANE_REGS     = 6;
    localparam int ENABLE_W       = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int NUM_PLANES_DEF = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_0 = 3'd0,
        CFG_PLANE_1 = 3'd1,
        CFG_PLANE_2 = 3'd2,
        CFG_PLANE_3 = 3'd3,
        CFG_PLANE_4 = 3'd4,
        CFG_PLANE_5 = 3'd5,
        CFG_ENABLE  = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_INSIDE    = 2'd2
    } verdict_t;

    // Packed plane register: offset in the top bits, nx in the bottom bits.
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nx;
    } plane_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ftc_item_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum cull item channel
// Valid/ready channel carrying one bounding volume per beat.
// ----------------------------------------------------------------------------
interface ftc_item_if;
    import ftc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [COORD_W-1:0]  first_x;
    logic signed [COORD_W-1:0]  first_y;
    logic signed [COORD_W-1:0]  first_z;
    logic signed [COORD_W-1:0]  second_x;
    logic signed [COORD_W-1:0]  second_y;
    logic signed [COORD_W-1:0]  second_z;
    logic [RADIUS_W-1:0]        radius;

    modport source (
        output valid, kind, first_x, first_y, first_z,
               second_x, second_y, second_z, radius,
        input  ready
    );

    modport sink (
        input  valid, kind, first_x, first_y, first_z,
               second_x, second_y, second_z, radius,
        output ready
    );

endinterface
`default_nettype wire

// ----- hw/rtl/ftc_result_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum cull result channel
// Valid/ready channel carrying one verdict per beat.
// ----------------------------------------------------------------------------
interface ftc_result_if;
    import ftc_pkg::*;

    logic     valid;
    logic     ready;
    verdict_t verdict;

    modport source (
        output valid, verdict,
        input  ready
    );

    modport sink (
        input  valid, verdict,
        output ready
    );

endinterface
`default_nettype wire

// ----- hw/rtl/frustum_cull_test_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum cull test
// Classifies a box or a sphere against up to six planes as outside,
// intersecting or inside.
// ----------------------------------------------------------------------------
// Usage:
// The item channel takes one bounding volume per beat (box corners or sphere
// centre and radius); the result channel returns one verdict per item, in
// order. Planes and the enable mask are written through the cfg_we/cfg_index/
// cfg_data port while no item is in flight.
// The pipeline has four register stages: corner selection, the products,
// the plane distances, and the compare with the verdict register. One item
// is taken every cycle while the receiver does not stall; the rate is set by
// the single pass of each item through the stages.
// Each stage holds its beat while the stage after it is full, so a stalled
// receiver stops the pipe from the output end and empty stages still fill.
// Reset clears all valid bits, zeroes the planes and enables every plane.
// ----------------------------------------------------------------------------
module frustum_cull_test_top #(
    parameter int NUM_PLANES = ftc_pkg::NUM_PLANES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ftc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ftc_pkg::CFG_DATA_W-1:0] cfg_data,
    ftc_item_if.sink                       item,
    ftc_result_if.source                   result
);
    import ftc_pkg::*;

    localparam int NPR = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;

    plane_t                    plane_reg [NPR];
    logic [ENABLE_W-1:0]       enable_reg;

    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    logic                      s3_valid_reg;
    logic                      result_valid_reg;
    logic                      s1_ready;
    logic                      s2_ready;
    logic                      s3_ready;
    logic                      s4_ready;

    logic signed [COORD_W-1:0] first_c [AXES];
    logic signed [COORD_W-1:0] second_c [AXES];
    logic signed [COORD_W-1:0] norm_c [NPR][AXES];
    logic signed [COORD_W-1:0] near_next [NPR][AXES];
    logic signed [COORD_W-1:0] far_next [NPR][AXES];
    logic [THR_W-1:0]          thr_next;

    logic signed [COORD_W-1:0] s1_near_reg [NPR][AXES];
    logic signed [COORD_W-1:0] s1_far_reg [NPR][AXES];
    logic [THR_W-1:0]          s1_thr_reg;
    logic signed [PROD_W-1:0]  s2_pn_reg [NPR][AXES];
    logic signed [PROD_W-1:0]  s2_pf_reg [NPR][AXES];
    logic [THR_W-1:0]          s2_thr_reg;
    logic signed [DIST_W-1:0]  s3_dn_reg [NPR];
    logic signed [DIST_W-1:0]  s3_df_reg [NPR];
    logic [THR_W-1:0]          s3_thr_reg;

    logic signed [DIST_W-1:0]  thr_s;
    logic [NPR-1:0]            en_mask;
    logic [NPR-1:0]            reject;
    logic [NPR-1:0]            straddle;
    verdict_t                  verdict_next;
    verdict_t                  verdict_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NPR; p++)
            begin
                plane_reg[p] <= '0;
            end
            enable_reg <= '1;
        end
        else if (cfg_we)
        begin
            for (int p = 0; p < NPR; p++)
            begin
                if (cfg_index == CFG_IDX_W'(p))
                begin
                    plane_reg[p] <= plane_t'(cfg_data);
                end
            end
            if (cfg_index == CFG_ENABLE)
            begin
                enable_reg <= cfg_data[ENABLE_W-1:0];
            end
        end
    end

    // Handshake: a stage loads when it is empty or the next stage takes its beat.
    assign s4_ready   = !result_valid_reg || result.ready;
    assign s3_ready   = !s3_valid_reg || s4_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                result_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1: near and far corners per plane; a sphere uses its centre for both.
    always_comb
    begin
        first_c[0]  = item.first_x;
        first_c[1]  = item.first_y;
        first_c[2]  = item.first_z;
        second_c[0] = item.second_x;
        second_c[1] = item.second_y;
        second_c[2] = item.second_z;
        for (int p = 0; p < NPR; p++)
        begin
            norm_c[p][0] = plane_reg[p].nx;
            norm_c[p][1] = plane_reg[p].ny;
            norm_c[p][2] = plane_reg[p].nz;
            for (int a = 0; a < AXES; a++)
            begin
                if (item.kind)
                begin
                    near_next[p][a] = first_c[a];
                    far_next[p][a]  = first_c[a];
                end
                else if (norm_c[p][a] > 0)
                begin
                    near_next[p][a] = first_c[a];
                    far_next[p][a]  = second_c[a];
                end
                else
                begin
                    near_next[p][a] = second_c[a];
                    far_next[p][a]  = first_c[a];
                end
            end
        end
        thr_next = item.kind ? {item.radius, FRAC_BITS'(0)} : '0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && item.valid)
        begin
            s1_near_reg <= near_next;
            s1_far_reg  <= far_next;
            s1_thr_reg  <= thr_next;
        end
    end

    // Stage 2: one product per axis for each corner.
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            for (int p = 0; p < NPR; p++)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    s2_pn_reg[p][a] <= norm_c[p][a] * s1_near_reg[p][a];
                    s2_pf_reg[p][a] <= norm_c[p][a] * s1_far_reg[p][a];
                end
            end
            s2_thr_reg <= s1_thr_reg;
        end
    end

    // Stage 3: signed distances in units of 2^-14.
    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            for (int p = 0; p < NPR; p++)
            begin
                s3_dn_reg[p] <= DIST_W'(s2_pn_reg[p][0]) + DIST_W'(s2_pn_reg[p][1])
                              + DIST_W'(s2_pn_reg[p][2])
                              + (DIST_W'(plane_reg[p].d) <<< FRAC_BITS);
                s3_df_reg[p] <= DIST_W'(s2_pf_reg[p][0]) + DIST_W'(s2_pf_reg[p][1])
                              + DIST_W'(s2_pf_reg[p][2])
                              + (DIST_W'(plane_reg[p].d) <<< FRAC_BITS);
            end
            s3_thr_reg <= s2_thr_reg;
        end
    end

    // Stage 4: per-plane compare and the combined verdict.
    assign thr_s   = $signed({{(DIST_W-THR_W){1'b0}}, s3_thr_reg});
    assign en_mask = enable_reg[NPR-1:0];

    always_comb
    begin
        for (int p = 0; p < NPR; p++)
        begin
            reject[p]   = en_mask[p] && (s3_dn_reg[p] > thr_s);
            straddle[p] = en_mask[p] && (s3_df_reg[p] >= -thr_s);
        end
        if (|reject)
        begin
            verdict_next = VERDICT_OUTSIDE;
        end
        else if (|straddle)
        begin
            verdict_next = VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.verdict = verdict_reg;

`ifndef ASSERT_OFF
    // Input back-pressure only appears once every stage holds a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && result_valid_reg))
        else $error("item channel stalled with an empty pipeline stage");

    // A beat in the distance stage moves into the output register when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s4_ready) |=> result.valid)
        else $error("beat lost between distance stage and output register");

    // With every plane disabled the verdict is always inside.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s4_ready && (en_mask == '0)) |=> (result.verdict == VERDICT_INSIDE))
        else $error("verdict not inside with all planes disabled");

    // A beat taken at the input reaches the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> s1_valid_reg)
        else $error("accepted item did not enter the first stage");
`endif

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frustum cull test testbench
// Sends boxes and spheres through the item channel under several plane and
// enable settings, predicts every verdict in a small scoreboard and checks
// each result beat in order, with bursty sending and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
    import ftc_pkg::*;

    localparam logic [CFG_IDX_W-1:0]      CFG_SPARE   = 3'd7;
    localparam logic                      KIND_BOX    = 1'b0;
    localparam logic                      KIND_SPHERE = 1'b1;
    localparam logic [ENABLE_W-1:0]       ENABLE_ALL  = '1;
    localparam logic [ENABLE_W-1:0]       ENABLE_NONE = '0;
    localparam logic signed [COORD_W-1:0] UNIT        = 16'sd16384;
    localparam logic signed [COORD_W-1:0] COORD_MAX   = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN   = 16'sh8000;
    localparam logic [RADIUS_W-1:0]       RADIUS_MAX  = '1;
    localparam int                        IDLE_LIMIT  = 2000;
    localparam int                        PHASES      = 13;
    localparam int                        PHASE_ITEMS = 150;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic [RADIUS_W-1:0]       radius;
    } volume_t;

    class cull_scoreboard;
        plane_t              planes[PLANE_REGS];
        logic [ENABLE_W-1:0] enable;
        verdict_t            pending_verdicts[$];
        int                  mismatches;

        function new();
            foreach (planes[i])
                planes[i] = '0;
            enable     = ENABLE_ALL;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_PLANE_0, CFG_PLANE_1, CFG_PLANE_2,
                CFG_PLANE_3, CFG_PLANE_4, CFG_PLANE_5:
                    planes[index] = data;
                CFG_ENABLE:
                    enable = data[ENABLE_W-1:0];
                default:
                    ;
            endcase
        endfunction

        function longint plane_distance(plane_t p, logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y,
                                        logic signed [COORD_W-1:0] z);
            return longint'($signed(p.nx)) * longint'(x)
                 + longint'($signed(p.ny)) * longint'(y)
                 + longint'($signed(p.nz)) * longint'(z)
                 + longint'($signed(p.d)) * (longint'(1) <<< FRAC_BITS);
        endfunction

        function verdict_t predict_verdict(volume_t v);
            longint reach;
            longint near_dist;
            longint far_dist;
            bit     rejected;
            bit     straddled;
            plane_t p;
            rejected  = 1'b0;
            straddled = 1'b0;
            reach     = longint'(v.radius) <<< FRAC_BITS;
            for (int i = 0; i < PLANE_REGS; i++) begin
                if (!enable[i])
                    continue;
                p = planes[i];
                if (v.kind == KIND_SPHERE) begin
                    near_dist = plane_distance(p, v.first_x, v.first_y, v.first_z);
                    if (near_dist > reach)
                        rejected = 1'b1;
                    else if (near_dist >= -reach)
                        straddled = 1'b1;
                end
                else begin
                    near_dist = plane_distance(p,
                        ($signed(p.nx) > 0) ? v.first_x : v.second_x,
                        ($signed(p.ny) > 0) ? v.first_y : v.second_y,
                        ($signed(p.nz) > 0) ? v.first_z : v.second_z);
                    far_dist = plane_distance(p,
                        ($signed(p.nx) > 0) ? v.second_x : v.first_x,
                        ($signed(p.ny) > 0) ? v.second_y : v.first_y,
                        ($signed(p.nz) > 0) ? v.second_z : v.first_z);
                    if (near_dist > 0)
                        rejected = 1'b1;
                    else if (far_dist >= 0)
                        straddled = 1'b1;
                end
            end
            return rejected ? VERDICT_OUTSIDE :
                   (straddled ? VERDICT_INTERSECT : VERDICT_INSIDE);
        endfunction

        function void note_item(volume_t v);
            pending_verdicts.push_back(predict_verdict(v));
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: verdict %0d arrived with no item pending", $time, got);
                return;
            end
            want = pending_verdicts.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: verdict mismatch: expected %0d, got %0d",
                             $time, want, got);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [15:0]           ready_pattern = '1;
    logic [3:0]            stall_step = '0;
    int                    idle_cycles = 0;
    cull_scoreboard        board = new();

    ftc_item_if   item_ch ();
    ftc_result_if result_ch ();

    frustum_cull_test_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        stall_step      <= stall_step + 4'd1;
        result_ch.ready <= ready_pattern[stall_step];
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            board.check_result(result_ch.verdict);
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] index,
                                  logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        board.set_register(index, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_cube(logic signed [COORD_W-1:0] half);
        plane_t p;
        for (int i = 0; i < PLANE_REGS; i++) begin
            p   = '0;
            p.d = -half;
            case (i / 2)
                0:       p.nx = (i % 2 == 0) ? UNIT : -UNIT;
                1:       p.ny = (i % 2 == 0) ? UNIT : -UNIT;
                default: p.nz = (i % 2 == 0) ? UNIT : -UNIT;
            endcase
            write_register(CFG_IDX_W'(CFG_PLANE_0 + i), p);
        end
    endtask

    task automatic send_volume(volume_t v);
        item_ch.valid    <= 1'b1;
        item_ch.kind     <= v.kind;
        item_ch.first_x  <= v.first_x;
        item_ch.first_y  <= v.first_y;
        item_ch.first_z  <= v.first_z;
        item_ch.second_x <= v.second_x;
        item_ch.second_y <= v.second_y;
        item_ch.second_z <= v.second_z;
        item_ch.radius   <= v.radius;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        board.note_item(v);
    endtask

    task automatic wait_for_drain();
        item_ch.valid <= 1'b0;
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic volume_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
        volume_t v;
        v          = '0;
        v.kind     = KIND_BOX;
        v.first_x  = COORD_W'(x0);
        v.first_y  = COORD_W'(y0);
        v.first_z  = COORD_W'(z0);
        v.second_x = COORD_W'(x1);
        v.second_y = COORD_W'(y1);
        v.second_z = COORD_W'(z1);
        return v;
    endfunction

    function automatic volume_t make_sphere(int x, int y, int z, int r);
        volume_t v;
        v         = '0;
        v.kind    = KIND_SPHERE;
        v.first_x = COORD_W'(x);
        v.first_y = COORD_W'(y);
        v.first_z = COORD_W'(z);
        v.radius  = RADIUS_W'(r);
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(int span);
        return COORD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic void axis_bounds(int span, output logic signed [COORD_W-1:0] lo,
                                        output logic signed [COORD_W-1:0] hi);
        int a;
        int b;
        a = near_coord(span);
        b = a + int'($urandom_range(0, span));
        if (b > 32767)
            b = 32767;
        if ($urandom_range(0, 15) == 0) begin
            lo = COORD_W'(b);
            hi = COORD_W'(a);
        end
        else begin
            lo = COORD_W'(a);
            hi = COORD_W'(b);
        end
    endfunction

    function automatic volume_t random_volume(int span);
        volume_t v;
        v.kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) begin
            v.first_x  = COORD_W'($urandom());
            v.first_y  = COORD_W'($urandom());
            v.first_z  = COORD_W'($urandom());
            v.second_x = COORD_W'($urandom());
            v.second_y = COORD_W'($urandom());
            v.second_z = COORD_W'($urandom());
            v.radius   = RADIUS_W'($urandom());
        end
        else begin
            axis_bounds(span, v.first_x, v.second_x);
            axis_bounds(span, v.first_y, v.second_y);
            axis_bounds(span, v.first_z, v.second_z);
            v.radius = RADIUS_W'($urandom_range(0, span));
        end
        return v;
    endfunction

    function automatic plane_t random_plane();
        plane_t                    p;
        logic signed [COORD_W-1:0] sign;
        p = '0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                sign = $urandom_range(0, 1) ? UNIT : -UNIT;
                case ($urandom_range(0, 2))
                    0:       p.nx = sign;
                    1:       p.ny = sign;
                    default: p.nz = sign;
                endcase
                p.d = -COORD_W'($urandom_range(0, 2000));
            end
            5, 6, 7:
            begin
                p.nx = near_coord(16384);
                p.ny = near_coord(16384);
                p.nz = near_coord(16384);
                p.d  = near_coord(2000);
            end
            8:
                p = {$urandom(), $urandom()};
            default:
                p = '0;
        endcase
        return p;
    endfunction

    task automatic configure_phase(int phase);
        plane_t p;
        if (phase == 0)
            write_cube(16'sd1000);
        else begin
            for (int i = 0; i < PLANE_REGS; i++) begin
                case (phase)
                    1:       p = '1;
                    4:       p = (i % 2) ? {4{COORD_MAX}} : {4{COORD_MIN}};
                    default: p = random_plane();
                endcase
                write_register(CFG_IDX_W'(CFG_PLANE_0 + i), p);
            end
        end
        if (phase == 2)
            write_register(CFG_ENABLE, CFG_DATA_W'(ENABLE_NONE));
        else if (phase % 4 == 3)
            write_register(CFG_ENABLE, CFG_DATA_W'(ENABLE_W'($urandom())));
        else
            write_register(CFG_ENABLE, CFG_DATA_W'(ENABLE_ALL));
    endtask

    task automatic send_random_phase(int count, int span, int max_gap, bit pause_midway);
        int burst;
        int gap;
        int n;
        burst = $urandom_range(1, 24);
        for (n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2)
                wait_for_drain();
            send_volume(random_volume(span));
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = $urandom_range(0, max_gap);
                if (gap > 0) begin
                    item_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.kind       <= KIND_BOX;
        item_ch.first_x    <= '0;
        item_ch.first_y    <= '0;
        item_ch.first_z    <= '0;
        item_ch.second_x   <= '0;
        item_ch.second_y   <= '0;
        item_ch.second_z   <= '0;
        item_ch.radius     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the planes still zero after reset, everything straddles.
        send_volume(make_box(-5, -5, -5, 5, 5, 5));
        send_volume(make_sphere(100, -100, 7, 3));
        wait_for_drain();

        write_cube(16'sd1000);
        send_volume(make_box(-10, -10, -10, 10, 10, 10));
        send_volume(make_box(1500, 0, 0, 1600, 10, 10));
        send_volume(make_box(900, 0, 0, 1100, 10, 10));
        send_volume(make_box(-1000, -1000, -1000, 1000, 1000, 1000));
        send_volume(make_box(100, 100, 100, -100, -100, -100));
        send_volume(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_volume(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_volume(make_sphere(0, 0, 0, 0));
        send_volume(make_sphere(1000, 0, 0, 0));
        send_volume(make_sphere(1001, 0, 0, 0));
        send_volume(make_sphere(2000, 0, 0, 1000));
        send_volume(make_sphere(0, 0, 0, RADIUS_MAX));
        send_volume(make_sphere(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX));
        wait_for_drain();

        // With no plane enabled, every volume counts as inside.
        write_register(CFG_ENABLE, CFG_DATA_W'(ENABLE_NONE));
        send_volume(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        send_volume(make_sphere(COORD_MAX, COORD_MIN, COORD_MAX, RADIUS_MAX));
        wait_for_drain();

        // Unnormalised normals: all ones in one plane, the extremes of their range in the other.
        write_register(CFG_PLANE_0, '1);
        write_register(CFG_PLANE_1, {COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN});
        write_register(CFG_ENABLE, CFG_DATA_W'(6'b000011));
        write_register(CFG_SPARE, {$urandom(), $urandom()});
        send_volume(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_volume(make_sphere(COORD_MAX, COORD_MAX, COORD_MAX, 0));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_drain();
            ready_pattern <= (phase % 3 == 2) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
            configure_phase(phase);
            send_random_phase(PHASE_ITEMS, (phase % 4 == 1) ? 32767 : 3000,
                              (phase % 3 == 2) ? 0 : 8, phase % 3 == 0);
        end

        wait_for_drain();
        repeat (8) @(posedge clk);
        board.mismatches += board.pending_verdicts.size();
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- frustum_cull_test_top.f -----
hw/rtl/ftc_pkg.sv
hw/rtl/ftc_item_if.sv
hw/rtl/ftc_result_if.sv
hw/rtl/frustum_cull_test_top.sv
test/testbench.sv
